### design/fdf_pkg.sv
// Shared constants, types and state encodings for the fractional derivative FIR.
// Used by fdf_wgen, fdf_mac and fractional_derivative_fir_core; depends on nothing.

package fdf_pkg;

   // Default sizing
   localparam int TAPS_DEFAULT         = 1024;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

   // Port field widths
   localparam int IN_WIDTH    = 16;
   localparam int OUT_WIDTH   = 20;
   localparam int ALPHA_WIDTH = 18;
   localparam int ALPHA_FRAC  = 16;

   // Weights are Q2.30
   localparam int WEIGHT_WIDTH = 32;
   localparam int FRAC_BITS    = 30;

   localparam logic [ALPHA_WIDTH-1:0]  ALPHA_RESET = 18'd32768;
   localparam logic [WEIGHT_WIDTH-1:0] W_ONE       = 32'h4000_0000;
   localparam logic [WEIGHT_WIDTH-1:0] W_MAX       = 32'h7FFF_FFFF;
   localparam logic [WEIGHT_WIDTH-1:0] W_MIN       = 32'h8000_0000;

   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = 20'sh7FFFF;
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = 20'sh80000;

   // Top level sequencing
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GEN,
      ST_MAC,
      ST_DRAIN
   } fdf_state_type;

   // Weight generator sequencing
   typedef enum logic [2:0] {
      WG_IDLE,
      WG_MUL,
      WG_PREP,
      WG_DIV,
      WG_STORE
   } fdf_wg_state_type;

   // One finished result
   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] derivative;
      logic                        saturated;
   } fdf_result_type;

endpackage

### design/fdf_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.

module fdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

### design/fdf_wgen.sv
// Grunwald-Letnikov weight generator: w_k = w_{k-1}*(k-1-alpha)/k, Q2.30, rounded.
// Shared multiplier plus a bit-serial restoring divider. Uses fdf_pkg.

module fdf_wgen #(
   parameter int TAPS = fdf_pkg::TAPS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [fdf_pkg::ALPHA_WIDTH-1:0]   alpha,
   output logic                              done,
   output logic                              wr_en,
   output logic [$clog2(TAPS)-1:0]           wr_addr,
   output logic [fdf_pkg::WEIGHT_WIDTH-1:0]  wr_data
);

   localparam int KW  = $clog2(TAPS);
   localparam int NW  = (KW + fdf_pkg::ALPHA_FRAC > fdf_pkg::ALPHA_WIDTH) ?
                        KW + fdf_pkg::ALPHA_FRAC : fdf_pkg::ALPHA_WIDTH;
   localparam int WW  = fdf_pkg::WEIGHT_WIDTH;
   localparam int PRW = WW + NW;
   localparam int DVW = PRW + 1 - fdf_pkg::ALPHA_FRAC;
   localparam int CW  = $clog2(DVW);

   fdf_pkg::fdf_wg_state_type state_ff, state_in;

   logic [WW-1:0]  w_ff, w_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic           neg_ff, neg_in;
   logic [DVW-1:0] div_ff, div_in;
   logic [KW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  bit_ff, bit_in;

   logic [KW-1:0]  k_m1;
   logic [NW-1:0]  num_k;
   logic [NW-1:0]  num_a;
   logic [NW:0]    numer;
   logic           neg_n;
   logic [NW-1:0]  mn;
   logic [WW-1:0]  mw;
   logic [PRW:0]   rnd_sum;
   logic [KW:0]    trial;
   logic           ge;
   logic           big;
   logic           q_is_min;
   logic           last_k;
   logic [WW-1:0]  w_new;

   // numerator (k-1)*2^16 - alpha and magnitudes of both factors
   always_comb begin
      k_m1  = k_ff - KW'(1);
      num_k = NW'({k_m1, {fdf_pkg::ALPHA_FRAC{1'b0}}});
      num_a = NW'(alpha);
      numer = {1'b0, num_k} - {1'b0, num_a};
      neg_n = numer[NW];
      mn    = neg_n ? NW'(-numer) : numer[NW-1:0];
      mw    = w_ff[WW-1] ? -w_ff : w_ff;
   end

   // rounding offset: half of k*2^16, then drop the 2^16
   assign rnd_sum = (PRW+1)'(prod_ff) + (PRW+1)'({k_ff, {(fdf_pkg::ALPHA_FRAC-1){1'b0}}});

   // one restoring division step
   always_comb begin
      trial = {rem_ff, div_ff[DVW-1]};
      ge    = trial >= {1'b0, k_ff};
   end

   // quotient to weight with sign and Q2.30 saturation
   always_comb begin
      big      = |div_ff[DVW-1:WW-1];
      q_is_min = div_ff == (DVW'(1) << (WW-1));
      if (neg_ff) begin
         w_new = (big && !q_is_min) ? fdf_pkg::W_MIN : -div_ff[WW-1:0];
      end else begin
         w_new = big ? fdf_pkg::W_MAX : div_ff[WW-1:0];
      end
   end

   assign last_k = k_ff == KW'(TAPS - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdf_pkg::WG_IDLE: begin
            if (start) begin
               state_in = fdf_pkg::WG_MUL;
            end
         end
         fdf_pkg::WG_MUL:  state_in = fdf_pkg::WG_PREP;
         fdf_pkg::WG_PREP: state_in = fdf_pkg::WG_DIV;
         fdf_pkg::WG_DIV: begin
            if (bit_ff == '0) begin
               state_in = fdf_pkg::WG_STORE;
            end
         end
         fdf_pkg::WG_STORE: begin
            state_in = last_k ? fdf_pkg::WG_IDLE : fdf_pkg::WG_MUL;
         end
         default: state_in = fdf_pkg::WG_IDLE;
      endcase
   end

   // outputs: weight RAM write and completion
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = w_new;
      done    = 1'b0;
      case (state_ff)
         fdf_pkg::WG_IDLE: begin
            if (start) begin
               wr_en   = 1'b1;
               wr_addr = '0;
               wr_data = fdf_pkg::W_ONE;
            end
         end
         fdf_pkg::WG_STORE: begin
            wr_en = 1'b1;
            done  = last_k;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      w_in    = w_ff;
      k_in    = k_ff;
      prod_in = prod_ff;
      neg_in  = neg_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      bit_in  = bit_ff;
      case (state_ff)
         fdf_pkg::WG_IDLE: begin
            if (start) begin
               w_in = fdf_pkg::W_ONE;
               k_in = KW'(1);
            end
         end
         fdf_pkg::WG_MUL: begin
            prod_in = mw * mn;
            neg_in  = neg_n ^ w_ff[WW-1];
         end
         fdf_pkg::WG_PREP: begin
            div_in = rnd_sum[PRW:fdf_pkg::ALPHA_FRAC];
            rem_in = '0;
            bit_in = CW'(DVW - 1);
         end
         fdf_pkg::WG_DIV: begin
            rem_in = ge ? KW'(trial - {1'b0, k_ff}) : trial[KW-1:0];
            div_in = {div_ff[DVW-2:0], ge};
            bit_in = bit_ff - CW'(1);
         end
         fdf_pkg::WG_STORE: begin
            w_in = w_new;
            k_in = k_ff + KW'(1);
         end
         default: begin
            w_in = w_ff;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fdf_pkg::WG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      w_ff    <= w_in;
      k_ff    <= k_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
   end

endmodule

### design/fdf_mac.sv
// Shared multiply-accumulate walking weight and sample history memories, with
// rounding and output saturation. Uses fdf_pkg.

module fdf_mac #(
   parameter int TAPS         = fdf_pkg::TAPS_DEFAULT,
   parameter int SAMPLE_WIDTH = fdf_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [$clog2(TAPS)-1:0]            base,
   input  logic [$clog2(TAPS+1)-1:0]          fill,
   output logic [$clog2(TAPS)-1:0]            hist_addr,
   input  logic signed [SAMPLE_WIDTH-1:0]     hist_data,
   output logic [$clog2(TAPS)-1:0]            wt_addr,
   input  logic [fdf_pkg::WEIGHT_WIDTH-1:0]   wt_data,
   output logic                               done,
   output fdf_pkg::fdf_result_type            result
);

   localparam int KW      = $clog2(TAPS);
   localparam int FW      = $clog2(TAPS + 1);
   localparam int PRW     = fdf_pkg::WEIGHT_WIDTH + SAMPLE_WIDTH;
   localparam int TOP     = fdf_pkg::OUT_WIDTH + fdf_pkg::FRAC_BITS - 1;
   localparam int ACC_NAT = PRW + KW + 1;
   localparam int AW      = (ACC_NAT > TOP + 2) ? ACC_NAT : TOP + 2;

   logic                  run_ff, run_in;
   logic [KW-1:0]         idx_ff, idx_in;
   logic [KW-1:0]         hptr_ff, hptr_in;
   logic                  s1_vld_ff, s1_live_ff, s1_last_ff;
   logic                  s2_vld_ff, s2_last_ff;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0]  acc_ff, acc_in;
   logic                  done_ff;

   logic                  issue_last;
   logic signed [AW-1:0]  rnd;
   logic [AW-1-TOP:0]     hi;
   logic                  in_range;

   assign issue_last = idx_ff == KW'(TAPS - 1);
   assign wt_addr    = idx_ff;
   assign hist_addr  = hptr_ff;

   // issue counter: weight index up, history index down with wrap
   always_comb begin
      run_in  = run_ff;
      idx_in  = idx_ff;
      hptr_in = hptr_ff;
      if (start) begin
         run_in  = 1'b1;
         idx_in  = '0;
         hptr_in = base;
      end else if (run_ff) begin
         run_in  = !issue_last;
         idx_in  = idx_ff + KW'(1);
         hptr_in = (hptr_ff == '0) ? KW'(TAPS - 1) : hptr_ff - KW'(1);
      end
   end

   // multiply; entries older than the fill count read as zero
   always_comb begin
      prod_in = '0;
      if (s1_live_ff) begin
         prod_in = $signed(wt_data) * hist_data;
      end
   end

   // accumulate
   always_comb begin
      acc_in = acc_ff;
      if (start) begin
         acc_in = '0;
      end else if (s2_vld_ff) begin
         acc_in = acc_ff + AW'(prod_ff);
      end
   end

   // round half up and saturate to the output range
   always_comb begin
      rnd      = acc_ff + (AW'(1) << (fdf_pkg::FRAC_BITS - 1));
      hi       = rnd[AW-1:TOP];
      in_range = (&hi) || !(|hi);
      if (in_range) begin
         result.derivative = $signed(rnd[TOP:fdf_pkg::FRAC_BITS]);
      end else begin
         result.derivative = rnd[AW-1] ? fdf_pkg::OUT_MIN : fdf_pkg::OUT_MAX;
      end
      result.saturated = !in_range;
   end

   assign done = done_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         run_ff    <= run_in;
         s1_vld_ff <= run_ff;
         s2_vld_ff <= s1_vld_ff;
         done_ff   <= s2_vld_ff && s2_last_ff;
      end
      idx_ff     <= idx_in;
      hptr_ff    <= hptr_in;
      s1_live_ff <= FW'(idx_ff) < fill;
      s1_last_ff <= issue_last;
      s2_last_ff <= s1_last_ff;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
   end

endmodule

### design/fractional_derivative_fir_core.sv
// Requests are taken only in the idle state: the single MAC walks both memories once per
// tap, and the next request waits until the result is loaded into the output register.
// The first request after reset or an order write also regenerates the weights first,
// with the bit-serial divider in fdf_wgen.
// Reset is synchronous, active high; history is zeroed via a fill count, no clearing pass.
// Top level: control FSM, history and weight RAMs, output register. Uses fdf_pkg,
// fdf_ram, fdf_wgen and fdf_mac.

module fractional_derivative_fir_core #(
   parameter int TAPS         = fdf_pkg::TAPS_DEFAULT,
   parameter int SAMPLE_WIDTH = fdf_pkg::SAMPLE_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [fdf_pkg::ALPHA_WIDTH-1:0]      csr_wr_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [fdf_pkg::IN_WIDTH-1:0]  req_sample,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fdf_pkg::OUT_WIDTH-1:0] rsp_derivative,
   output logic                                 rsp_saturated
);

   localparam int KW = $clog2(TAPS);
   localparam int FW = $clog2(TAPS + 1);
   localparam int PW = (SAMPLE_WIDTH > fdf_pkg::IN_WIDTH) ? SAMPLE_WIDTH : fdf_pkg::IN_WIDTH;
   localparam int WW = fdf_pkg::WEIGHT_WIDTH;

   fdf_pkg::fdf_state_type state_ff, state_in;

   logic [fdf_pkg::ALPHA_WIDTH-1:0]  alpha_ff, alpha_in;
   logic                             wready_ff, wready_in;
   logic [KW-1:0]                    ptr_ff, ptr_in;
   logic [KW-1:0]                    base_ff, base_in;
   logic [FW-1:0]                    fill_ff, fill_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [fdf_pkg::OUT_WIDTH-1:0] rsp_derivative_ff, rsp_derivative_in;
   logic                             rsp_saturated_ff, rsp_saturated_in;

   logic                             accept;
   logic                             wgen_start;
   logic                             wgen_done;
   logic                             mac_start;
   logic                             mac_done;
   logic                             out_free;
   logic                             load;
   fdf_pkg::fdf_result_type          mac_result;

   logic [PW-1:0]                    raw;
   logic [SAMPLE_WIDTH-1:0]          x;

   logic                             wt_wr_en;
   logic [KW-1:0]                    wt_wr_addr;
   logic [WW-1:0]                    wt_wr_data;
   logic [KW-1:0]                    wt_rd_addr;
   logic [WW-1:0]                    wt_rd_data;
   logic [KW-1:0]                    hist_rd_addr;
   logic [SAMPLE_WIDTH-1:0]          hist_rd_data;

   // only the low SAMPLE_WIDTH bits of the request count, as two's complement
   always_comb begin
      raw = PW'($unsigned(req_sample));
      x   = raw[SAMPLE_WIDTH-1:0];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fdf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = wready_ff ? fdf_pkg::ST_MAC : fdf_pkg::ST_GEN;
            end
         end
         fdf_pkg::ST_GEN: begin
            if (wgen_done) begin
               state_in = fdf_pkg::ST_MAC;
            end
         end
         fdf_pkg::ST_MAC: begin
            if (mac_done) begin
               state_in = fdf_pkg::ST_DRAIN;
            end
         end
         fdf_pkg::ST_DRAIN: begin
            if (out_free) begin
               state_in = fdf_pkg::ST_IDLE;
            end
         end
         default: state_in = fdf_pkg::ST_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_stall  = 1'b1;
      load       = 1'b0;
      case (state_ff)
         fdf_pkg::ST_IDLE:  req_stall = 1'b0;
         fdf_pkg::ST_DRAIN: load      = out_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
      accept     = req_valid && !req_stall;
      wgen_start = accept && !wready_ff;
      mac_start  = (accept && wready_ff) || wgen_done;
   end

   // configuration, history pointer and fill count
   always_comb begin
      alpha_in  = alpha_ff;
      wready_in = wready_ff;
      ptr_in    = ptr_ff;
      base_in   = base_ff;
      fill_in   = fill_ff;
      if (csr_wr_en) begin
         alpha_in  = csr_wr_data;
         wready_in = 1'b0;
      end else if (wgen_done) begin
         wready_in = 1'b1;
      end
      if (accept) begin
         base_in = ptr_ff;
         ptr_in  = (ptr_ff == KW'(TAPS - 1)) ? '0 : ptr_ff + KW'(1);
         fill_in = (fill_ff == FW'(TAPS)) ? fill_ff : fill_ff + FW'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in      = load || (rsp_valid_ff && rsp_stall);
      rsp_derivative_in = load ? mac_result.derivative : rsp_derivative_ff;
      rsp_saturated_in  = load ? mac_result.saturated : rsp_saturated_ff;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_derivative = rsp_derivative_ff;
   assign rsp_saturated  = rsp_saturated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdf_pkg::ST_IDLE;
         alpha_ff     <= fdf_pkg::ALPHA_RESET;
         wready_ff    <= 1'b0;
         ptr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alpha_ff     <= alpha_in;
         wready_ff    <= wready_in;
         ptr_ff       <= ptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff           <= base_in;
      rsp_derivative_ff <= rsp_derivative_in;
      rsp_saturated_ff  <= rsp_saturated_in;
   end

   // sample history, written once per request
   fdf_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ptr_ff),
      .wr_data (x),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   // Q2.30 weight table
   fdf_ram #(
      .WIDTH (WW),
      .DEPTH (TAPS)
   ) u_wt_ram (
      .clock   (clock),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (wt_wr_data),
      .rd_addr (wt_rd_addr),
      .rd_data (wt_rd_data)
   );

   fdf_wgen #(
      .TAPS (TAPS)
   ) u_wgen (
      .clock   (clock),
      .reset   (reset),
      .start   (wgen_start),
      .alpha   (alpha_ff),
      .done    (wgen_done),
      .wr_en   (wt_wr_en),
      .wr_addr (wt_wr_addr),
      .wr_data (wt_wr_data)
   );

   fdf_mac #(
      .TAPS         (TAPS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .start     (mac_start),
      .base      (base_in),
      .fill      (fill_in),
      .hist_addr (hist_rd_addr),
      .hist_data ($signed(hist_rd_data)),
      .wt_addr   (wt_rd_addr),
      .wt_data   (wt_rd_data),
      .done      (mac_done),
      .result    (mac_result)
   );

`ifndef SYNTHESIS
   a_mac_done_in_mac: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == fdf_pkg::ST_MAC)
      else $error("MAC finished outside the MAC phase");

   a_gen_done_in_gen: assert property (@(posedge clock) disable iff (reset)
      wgen_done |-> state_ff == fdf_pkg::ST_GEN)
      else $error("weight generation finished outside the generation phase");

   a_mac_needs_weights: assert property (@(posedge clock) disable iff (reset)
      state_ff == fdf_pkg::ST_MAC |-> wready_ff)
      else $error("MAC running on a stale weight table");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(TAPS) && ptr_ff <= KW'(TAPS - 1))
      else $error("history pointer or fill count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while held");
`endif

endmodule

### test/fractional_derivative_fir_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for fractional_derivative_fir_core: drives samples, predicts each
// Grunwald-Letnikov output in a local fixed-point model and checks every response.
// Depends on fdf_pkg and the core RTL only.

module fractional_derivative_fir_core_test;

   localparam int TAPS          = fdf_pkg::TAPS_DEFAULT;
   localparam int QUIET_LIMIT   = 200000;
   localparam int HOLD_AT       = 270;
   localparam int HOLD_CYCLES   = 6000;
   localparam int BATCH_ITEMS   = 56;
   localparam int CFG_SETTLE    = 8;

   localparam logic [fdf_pkg::ALPHA_WIDTH-1:0] ALPHA_ZERO = '0;
   localparam logic [fdf_pkg::ALPHA_WIDTH-1:0] ALPHA_ONE  = 18'd65536;
   localparam logic [fdf_pkg::ALPHA_WIDTH-1:0] ALPHA_TWO  = 18'd131072;
   localparam logic [fdf_pkg::ALPHA_WIDTH-1:0] ALPHA_TOP  = '1;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 csr_wr_en = 1'b0;
   logic [fdf_pkg::ALPHA_WIDTH-1:0]      csr_wr_data = '0;
   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [fdf_pkg::IN_WIDTH-1:0]  req_sample = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic signed [fdf_pkg::OUT_WIDTH-1:0] rsp_derivative;
   logic                                 rsp_saturated;

   // Local model state
   logic signed [fdf_pkg::IN_WIDTH-1:0]     hist_ram [TAPS];
   logic signed [fdf_pkg::WEIGHT_WIDTH-1:0] coef_ram [TAPS];
   int unsigned                             hist_wr_ptr;
   bit                                      coef_valid;
   logic [fdf_pkg::ALPHA_WIDTH-1:0]         order_q16;

   // Pending samples and outstanding expected outputs
   logic signed [fdf_pkg::IN_WIDTH-1:0] pending_samples [$];
   fdf_pkg::fdf_result_type             expected_derivatives [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatches         = 0;
   int requests_sent      = 0;
   int results_checked    = 0;
   int saturations        = 0;
   int order_writes       = 0;
   int hold_left          = 0;
   bit hold_done          = 1'b0;
   int quiet_cycles       = 0;

   fractional_derivative_fir_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_derivative (rsp_derivative),
      .rsp_saturated  (rsp_saturated)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Weight recursion w_k = w_{k-1} * (k-1-alpha) / k, magnitudes rounded half away
   // from zero, saturated to Q2.30 range
   function automatic void gl_weights_build();
      longint signed   w;
      longint signed   numer;
      longint unsigned mw, mn, den, q;
      bit              neg_n, neg_w;
      w = longint'(1) << fdf_pkg::FRAC_BITS;
      coef_ram[0] = w[31:0];
      for (int k = 1; k < TAPS; k++) begin
         numer = (longint'(k - 1) << fdf_pkg::ALPHA_FRAC) - longint'(order_q16);
         neg_n = numer < 0;
         neg_w = w < 0;
         mn    = neg_n ? longint'(-numer) : longint'(numer);
         mw    = neg_w ? longint'(-w) : longint'(w);
         den   = longint'(k) << fdf_pkg::ALPHA_FRAC;
         q     = (mw * mn + den / 2) / den;
         if (neg_n != neg_w) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            w = -longint'(q);
         end else begin
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            w = longint'(q);
         end
         coef_ram[k] = w[31:0];
      end
      coef_valid = 1'b1;
   endfunction

   // One output: exact convolution over the history, round half up, saturate to 20 bits
   function automatic fdf_pkg::fdf_result_type gl_derivative_predict(
      logic signed [fdf_pkg::IN_WIDTH-1:0] sample);
      fdf_pkg::fdf_result_type r;
      longint signed           acc;
      longint signed           lim;
      int unsigned             idx;
      if (!coef_valid) gl_weights_build();
      hist_ram[hist_wr_ptr] = sample;
      acc = 0;
      idx = hist_wr_ptr;
      for (int k = 0; k < TAPS; k++) begin
         acc += longint'(coef_ram[k]) * longint'(hist_ram[idx]);
         idx = (idx == 0) ? TAPS - 1 : idx - 1;
      end
      acc += longint'(1) << (fdf_pkg::FRAC_BITS - 1);
      lim = longint'(1) << 49;
      if (acc >= -lim && acc < lim) begin
         r.derivative = acc[49:30];
         r.saturated  = 1'b0;
      end else begin
         r.derivative = (acc < 0) ? fdf_pkg::OUT_MIN : fdf_pkg::OUT_MAX;
         r.saturated  = 1'b1;
      end
      hist_wr_ptr = (hist_wr_ptr + 1 >= TAPS) ? 0 : hist_wr_ptr + 1;
      return r;
   endfunction

   task automatic mismatch_report(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Request driver: prediction is made when the request is taken
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_derivatives.push_back(gl_derivative_predict(req_sample));
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid  <= 1'b1;
               req_sample <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and stall generator
   always @(posedge clock) begin : monitor
      fdf_pkg::fdf_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_derivatives.size() == 0) begin
               mismatch_report($sformatf("response %0d with nothing outstanding",
                                         rsp_derivative));
            end else begin
               want = expected_derivatives.pop_front();
               if (rsp_derivative !== want.derivative)
                  mismatch_report($sformatf("derivative %0d, expected %0d",
                                            rsp_derivative, want.derivative));
               if (rsp_saturated !== want.saturated)
                  mismatch_report($sformatf("saturated %0b, expected %0b",
                                            rsp_saturated, want.saturated));
            end
            results_checked++;
            if (rsp_saturated) saturations++;
         end
         // one long hold-off so the core backs up and stalls its input
         if (results_checked == HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $realtime, QUIET_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Mostly full-range noise, some rail values, some small values
   function automatic logic signed [fdf_pkg::IN_WIDTH-1:0] sample_pick();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 6)
         return fdf_pkg::IN_WIDTH'($urandom);
      else if (sel < 8)
         return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else
         return fdf_pkg::IN_WIDTH'($urandom_range(512)) - 16'sd256;
   endfunction

   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_derivatives.size() != 0)
         @(posedge clock);
   endtask

   // Order register is written only with the core idle
   task automatic order_write(input logic [fdf_pkg::ALPHA_WIDTH-1:0] value);
      repeat (CFG_SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      order_q16   = value;
      coef_valid  = 1'b0;
      order_writes++;
   endtask

   task automatic random_batch(input int send_pct, input int stall_pct);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < BATCH_ITEMS; i++)
         pending_samples.push_back(sample_pick());
      wait_drained();
   endtask

   initial begin : stimulus
      logic signed [fdf_pkg::IN_WIDTH-1:0] directed [] = '{
         16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001,
         16'shFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA,
         16'sh0000, 16'sh0000, 16'sd100, -16'sd100, 16'sd12345, -16'sd12345};

      for (int i = 0; i < TAPS; i++) begin
         hist_ram[i] = '0;
         coef_ram[i] = '0;
      end
      hist_wr_ptr = 0;
      coef_valid  = 1'b0;
      order_q16   = fdf_pkg::ALPHA_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // rails, steps and alternation at the reset order of one half
      foreach (directed[i]) pending_samples.push_back(directed[i]);
      wait_drained();

      // alpha 0: output follows the input
      order_write(ALPHA_ZERO);
      random_batch(51, 0);
      random_batch(0, 51);

      // alpha 2.0, top of the intended range
      order_write(ALPHA_TWO);
      random_batch(7, 7);
      random_batch(0, 0);

      // largest code, beyond 2.0: weights clip to the Q2.30 range
      order_write(ALPHA_TOP);
      random_batch(51, 0);
      random_batch(0, 51);

      order_write(ALPHA_ONE);
      random_batch(7, 7);
      random_batch(51, 0);

      order_write(fdf_pkg::ALPHA_WIDTH'($urandom_range(262143)));
      random_batch(0, 51);
      random_batch(0, 0);

      wait_drained();
      repeat (TAPS + 16) @(posedge clock);
      if (expected_derivatives.size() != 0)
         mismatch_report($sformatf("%0d responses never arrived",
                                   expected_derivatives.size()));

      $display("Covered %0d requests and %0d responses (%0d clipped) over %0d order settings,",
               requests_sent, results_checked, saturations, order_writes + 1);
      $display("with sender gaps, receiver stalls and one long back-pressure hold; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### sim.f
design/fdf_pkg.sv
design/fdf_ram.sv
design/fdf_wgen.sv
design/fdf_mac.sv
design/fractional_derivative_fir_core.sv
test/fractional_derivative_fir_core_test.sv
